// File: hdl/jetc_pkg.sv
package jetc_pkg;

   localparam int MAX_ITER_DEF   = 60;
   localparam int IMAGE_SIZE_DEF = 1024;
   localparam int FRAC_BITS      = 28;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_LEFT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_TOP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_C_RE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_C_IM    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE = 3'd5;

   localparam logic signed [31:0] X_LEFT_RST = -32'sd536870912;
   localparam logic signed [31:0] Y_TOP_RST  = 32'sd536870912;
   localparam logic [30:0]        STEP_RST   = 31'd1193046;
   localparam logic signed [30:0] C_RE_RST   = -31'sd80530637;
   localparam logic signed [30:0] C_IM_RST   = 31'sd214748365;
   localparam logic [2:0]         PAL_RST    = 3'd1;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = -32'sh8000_0000;

   // returns {r,g,b}
   function automatic logic [23:0] palette_rgb(input logic [2:0] pal, input logic [2:0] idx);
      logic [23:0] c;
      begin
         c = 24'h0;
         case (pal)
            3'd0: begin
               case (idx)
                  3'd0: c = {8'd0, 8'd5, 8'd21};
                  3'd1: c = {8'd37, 8'd44, 8'd63};
                  3'd2: c = {8'd95, 8'd165, 8'd178};
                  3'd3: c = {8'd240, 8'd235, 8'd148};
                  default: c = {8'd234, 8'd108, 8'd95};
               endcase
            end
            3'd1: begin
               case (idx)
                  3'd0: c = {8'd56, 8'd62, 8'd105};
                  3'd1: c = {8'd96, 8'd136, 8'd191};
                  3'd2: c = {8'd127, 8'd174, 8'd191};
                  3'd3: c = {8'd104, 8'd223, 8'd208};
                  default: c = {8'd173, 8'd255, 8'd238};
               endcase
            end
            3'd2: begin
               case (idx)
                  3'd0: c = {8'd158, 8'd47, 8'd54};
                  3'd1: c = {8'd245, 8'd140, 8'd107};
                  3'd2: c = {8'd250, 8'd229, 8'd77};
                  3'd3: c = {8'd255, 8'd230, 8'd148};
                  default: c = {8'd234, 8'd237, 8'd244};
               endcase
            end
            3'd3: begin
               case (idx)
                  3'd0: c = {8'd139, 8'd75, 8'd98};
                  3'd1: c = {8'd187, 8'd111, 8'd107};
                  3'd2: c = {8'd234, 8'd150, 8'd116};
                  3'd3: c = {8'd252, 8'd188, 8'd128};
                  default: c = {8'd247, 8'd226, 8'd156};
               endcase
            end
            default: begin
               case (idx)
                  3'd0: c = {8'd14, 8'd36, 8'd49};
                  3'd1: c = {8'd55, 8'd33, 8'd84};
                  3'd2: c = {8'd252, 8'd58, 8'd82};
                  3'd3: c = {8'd249, 8'd178, 8'd72};
                  default: c = {8'd232, 8'd213, 8'd183};
               endcase
            end
         endcase
         palette_rgb = c;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      begin
         if (v > 36'sh0_7FFF_FFFF) sat32 = S32_MAX;
         else if (v < -36'sh0_8000_0000) sat32 = S32_MIN;
         else sat32 = v[31:0];
      end
   endfunction

endpackage

// File: hdl/jetc_iter_stage.sv
// One escape-time iteration split over three registers:
// products, escape test / shift-add, saturate and hand on.
module jetc_iter_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic               in_done,
   input  logic [9:0]         in_count,
   input  logic signed [31:0] in_a,
   input  logic signed [31:0] in_b,
   input  logic signed [30:0] c_re,
   input  logic signed [30:0] c_im,
   input  logic [9:0]         iter_idx,
   output logic               out_valid,
   output logic               out_done,
   output logic [9:0]         out_count,
   output logic signed [31:0] out_a,
   output logic signed [31:0] out_b
);

   logic               v1_ff, v2_ff, v3_ff;
   logic               d1_ff, d2_ff, d3_ff;
   logic [9:0]         n1_ff, n2_ff, n3_ff;
   logic signed [63:0] aa_ff, bb_ff, ab_ff;
   logic signed [31:0] a1_ff, b1_ff;
   logic signed [35:0] na_ff, nb_ff;
   logic signed [31:0] a2_ff, b2_ff;
   logic signed [31:0] a3_ff, b3_ff;

   logic [64:0]        mag_in;
   logic               esc_in;
   logic signed [64:0] diff_in;
   logic signed [35:0] na_in, nb_in;

   always_comb begin
      mag_in  = {1'b0, aa_ff} + {1'b0, bb_ff};
      esc_in  = mag_in >= (65'd4 << 56);
      diff_in = {aa_ff[63], aa_ff} - {bb_ff[63], bb_ff};
      // arithmetic shift is floor rounding; values fit 36 bits before saturation
      na_in   = 36'(diff_in >>> 28) + 36'(c_re);
      nb_in   = 36'(ab_ff >>> 27) + 36'(c_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff <= in_done;
         n1_ff <= in_count;
         aa_ff <= in_a * in_a;
         bb_ff <= in_b * in_b;
         ab_ff <= in_a * in_b;
         a1_ff <= in_a;
         b1_ff <= in_b;

         d2_ff <= d1_ff | esc_in;
         n2_ff <= (d1_ff || esc_in) ? n1_ff : iter_idx + 10'd1;
         na_ff <= na_in;
         nb_ff <= nb_in;
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;

         d3_ff <= d2_ff;
         n3_ff <= n2_ff;
         a3_ff <= d2_ff ? a2_ff : jetc_pkg::sat32(na_ff);
         b3_ff <= d2_ff ? b2_ff : jetc_pkg::sat32(nb_ff);
      end
   end

   assign out_valid = v3_ff;
   assign out_done  = d3_ff;
   assign out_count = n3_ff;
   assign out_a     = a3_ff;
   assign out_b     = b3_ff;

endmodule

// File: hdl/julia_escape_time_colorizer.sv
// Julia set escape-time colorizer.
// Requests on req_ carry a pixel column and row; each yields one response on
// rsp_ holding an RGB color and the escape count. csr_ writes set the view
// window, the Julia constant and the palette; write only while idle.
// Pipeline: 3 coordinate stages, MAX_ITER iteration units of 3 stages each,
// and 3 color stages. Throughput: one pixel per clock while the receiver
// keeps taking responses; the unrolled iteration chain sets it.
// Every stage carries a valid bit; the whole pipe advances when the output
// register is empty or being read, so a stalled receiver freezes the pipe
// and nothing is lost or repeated. req_tready is low while the output holds
// a response that is not taken.
// Reset (synchronous, high) clears all valid bits and loads default
// registers: window from -2.0 / 2.0, step 1193046, c = -0.3 + 0.8i,
// palette 1.
// A pixel that never escapes reports escape_count MAX_ITER (masked to 6 bits).
module julia_escape_time_colorizer #(
   parameter int MAX_ITER = jetc_pkg::MAX_ITER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [9:0] pixel_col, [19:10] pixel_row
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [29:24] escape_count
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int SEG = MAX_ITER / 4;
   // ceil(2^32 / MAX_ITER): exact floor division for dividends below 2^32 / MAX_ITER
   localparam logic [31:0] RECIP =
      32'(((64'd1 << 32) + 64'(MAX_ITER) - 64'd1) / 64'(MAX_ITER));

   logic signed [31:0] x_left_ff, y_top_ff;
   logic [30:0]        step_ff;
   logic signed [30:0] c_re_ff, c_im_ff;
   logic [2:0]         pal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_left_ff <= jetc_pkg::X_LEFT_RST;
         y_top_ff  <= jetc_pkg::Y_TOP_RST;
         step_ff   <= jetc_pkg::STEP_RST;
         c_re_ff   <= jetc_pkg::C_RE_RST;
         c_im_ff   <= jetc_pkg::C_IM_RST;
         pal_ff    <= jetc_pkg::PAL_RST;
      end else if (csr_we) begin
         case (csr_index)
            jetc_pkg::CSR_X_LEFT:  x_left_ff <= csr_wdata;
            jetc_pkg::CSR_Y_TOP:   y_top_ff  <= csr_wdata;
            jetc_pkg::CSR_STEP:    step_ff   <= csr_wdata[30:0];
            jetc_pkg::CSR_C_RE:    c_re_ff   <= csr_wdata[30:0];
            jetc_pkg::CSR_C_IM:    c_im_ff   <= csr_wdata[30:0];
            jetc_pkg::CSR_PALETTE: pal_ff    <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // output register and global advance
   logic        out_v_ff;
   logic [31:0] out_d_ff;
   logic        adv;
   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   // coordinate stages
   logic        cv1_ff, cv2_ff, cv3_ff;
   logic [9:0]  col_ff, row_ff;
   logic [40:0] pc_ff, pr_ff;
   logic signed [31:0] a0_ff, b0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cv1_ff <= 1'b0;
         cv2_ff <= 1'b0;
         cv3_ff <= 1'b0;
      end else if (adv) begin
         cv1_ff <= req_tvalid;
         cv2_ff <= cv1_ff;
         cv3_ff <= cv2_ff;
      end
   end

   // offsets clamp at 2^33-1: anything that large saturates the sum anyway
   always_ff @(posedge clock) begin
      if (adv) begin
         col_ff <= req_tdata[9:0];
         row_ff <= req_tdata[19:10];
         pc_ff  <= col_ff * step_ff;
         pr_ff  <= row_ff * step_ff;
         a0_ff  <= jetc_pkg::sat32(36'(x_left_ff) + 36'(pc_ff > 41'h1_FFFF_FFFF ?
                   36'h1_FFFF_FFFF : 36'(pc_ff)));
         b0_ff  <= jetc_pkg::sat32(36'(y_top_ff) - 36'(pr_ff > 41'h1_FFFF_FFFF ?
                   36'h1_FFFF_FFFF : 36'(pr_ff)));
      end
   end

   // iteration chain
   logic               iv [MAX_ITER+1];
   logic               idn [MAX_ITER+1];
   logic [9:0]         icnt [MAX_ITER+1];
   logic signed [31:0] ia [MAX_ITER+1];
   logic signed [31:0] ib [MAX_ITER+1];

   assign iv[0]   = cv3_ff;
   assign idn[0]  = 1'b0;
   assign icnt[0] = 10'd0;
   assign ia[0]   = a0_ff;
   assign ib[0]   = b0_ff;

   for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
      jetc_iter_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (iv[k]),
         .in_done   (idn[k]),
         .in_count  (icnt[k]),
         .in_a      (ia[k]),
         .in_b      (ib[k]),
         .c_re      (c_re_ff),
         .c_im      (c_im_ff),
         .iter_idx  (10'(k)),
         .out_valid (iv[k+1]),
         .out_done  (idn[k+1]),
         .out_count (icnt[k+1]),
         .out_a     (ia[k+1]),
         .out_b     (ib[k+1])
      );
   end

   // color stages
   logic [9:0] n_fin;
   assign n_fin = idn[MAX_ITER] ? icnt[MAX_ITER] : 10'(MAX_ITER);

   logic        kv1_ff, kv2_ff;
   logic [9:0]  n1_ff, n2_ff;
   logic [9:0]  u1_ff;
   logic [2:0]  seg1_ff;
   logic [19:0] prod_ff [3];   // |hi - lo| * 4u
   logic [2:0]  neg_ff;        // hi below lo
   logic [23:0] lo2_ff;

   logic [2:0]  seg_in;
   logic [9:0]  u_in;
   logic [2:0]  pal_use;
   logic [23:0] lo_in, hi_in;
   logic [7:0]  dif_in [3];
   logic [51:0] quot_in [3];
   logic [23:0] rgb_in;

   always_comb begin
      if (n_fin <= 10'(SEG))          seg_in = 3'd0;
      else if (n_fin <= 10'(2 * SEG)) seg_in = 3'd1;
      else if (n_fin <= 10'(3 * SEG)) seg_in = 3'd2;
      else                            seg_in = 3'd3;
      // n mod SEG by compare and subtract against the segment multiples
      u_in = n_fin;
      for (int k = 1; k <= MAX_ITER / SEG; k++) begin
         if (n_fin >= 10'(k * SEG)) u_in = n_fin - 10'(k * SEG);
      end
      pal_use = (pal_ff > 3'd4) ? 3'd4 : pal_ff;
      lo_in   = jetc_pkg::palette_rgb(pal_use, seg1_ff);
      hi_in   = jetc_pkg::palette_rgb(pal_use, seg1_ff + 3'd1);
      for (int c = 0; c < 3; c++) begin
         dif_in[c] = (hi_in[c*8 +: 8] < lo_in[c*8 +: 8]) ?
                     lo_in[c*8 +: 8] - hi_in[c*8 +: 8] :
                     hi_in[c*8 +: 8] - lo_in[c*8 +: 8];
         // magnitude divided by MAX_ITER via reciprocal, sign applied after,
         // so the quotient truncates toward zero
         quot_in[c] = 52'(prod_ff[c]) * 52'(RECIP);
         rgb_in[c*8 +: 8] = neg_ff[c] ? lo2_ff[c*8 +: 8] - quot_in[c][39:32] :
                                        lo2_ff[c*8 +: 8] + quot_in[c][39:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kv1_ff   <= 1'b0;
         kv2_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         kv1_ff   <= iv[MAX_ITER];
         kv2_ff   <= kv1_ff;
         out_v_ff <= kv2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_ff   <= n_fin;
         seg1_ff <= seg_in;
         u1_ff   <= u_in;
         n2_ff   <= n1_ff;
         lo2_ff  <= lo_in;
         for (int c = 0; c < 3; c++) begin
            neg_ff[c]  <= hi_in[c*8 +: 8] < lo_in[c*8 +: 8];
            prod_ff[c] <= 20'(dif_in[c]) * 20'({u1_ff, 2'b00});
         end
         out_d_ff <= {2'b00, n2_ff[5:0], rgb_in[7:0], rgb_in[15:8], rgb_in[23:16]};
      end
   end

endmodule

// File: hdl/jetc_checker.sv
module jetc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped under stall");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while output stalled");

   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response after reset");

endmodule

bind julia_escape_time_colorizer jetc_checker u_jetc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
